### design/srrc_pkg.sv
// ----------------------------------------------------------------------------
// srrc_pkg
// Shared types, codes and the byte-wise CRC-32 step for the selective-repeat
// receiver.
// ----------------------------------------------------------------------------
package srrc_pkg;

	typedef struct packed {
		logic [1:0]  pkt_kind;
		logic [2:0]  frame_seq;
		logic [63:0] payload_lo;
		logic [63:0] payload_hi;
		logic [31:0] frame_crc;
	} frame_t;

	typedef struct packed {
		logic [1:0]  out_type;
		logic [2:0]  out_seq;
		logic [63:0] data_lo;
		logic [63:0] data_hi;
		logic        last_result;
	} result_t;

	localparam logic [1:0] KIND_DATA = 2'd0;

	localparam logic [1:0] OUT_NAK     = 2'd0;
	localparam logic [1:0] OUT_ACK     = 2'd1;
	localparam logic [1:0] OUT_DELIVER = 2'd2;

	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// deliveries per frame, not counting the ack, which is a separate result beat
	localparam int MAX_DELIV = 8;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### design/srrc_crc.sv
// ----------------------------------------------------------------------------
// srrc_crc
// Iterative CRC-32 unit: four payload bytes per cycle, bytes beyond the
// payload length are skipped.
// ----------------------------------------------------------------------------
module srrc_crc #(
	parameter int PAYLOAD_BYTES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] data,
	output logic         done,
	output logic [31:0]  crc
);

	localparam int NCHUNK = (PAYLOAD_BYTES + 3) / 4;
	localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   crc_q;
	logic [31:0]   chunk;
	logic [31:0]   crc_next;

	assign chunk = data[32*cnt_q +: 32];

	always_comb begin
		crc_next = crc_q;
		for (int j = 0; j < 4; j++) begin
			if ((int'(cnt_q) * 4 + j) < PAYLOAD_BYTES) begin
				crc_next = srrc_pkg::crc_byte(crc_next, chunk[8*j +: 8]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(NCHUNK - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NCHUNK - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= srrc_pkg::CRC_INIT;
		end else if (busy_q) begin
			crc_q <= crc_next;
		end
	end

	assign done = done_q;
	assign crc  = ~crc_q;

endmodule

### design/srrc_mem.sv
// ----------------------------------------------------------------------------
// srrc_mem
// Packet store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srrc_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [127:0]  wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [127:0]  rd_data
);

	logic [127:0] mem [DEPTH];
	logic [127:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/selective_repeat_receiver_crc_top.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_crc_top
// Receiving side of selective-repeat ARQ with CRC-32 frame check.
// ----------------------------------------------------------------------------
// Input channel frame/frame_valid/frame_ready carries one received frame per
// beat; result/result_valid/result_ready carries nak, ack and delivery beats,
// last_result marking the final beat caused by a frame.
// A data frame is checked by an iterative CRC unit at four bytes a cycle,
// which raises a registered done flag at the end; the nak or ack is then
// loaded into the output register from the check state once that register
// is free. A new in-window frame with a good CRC goes into the packet
// memory, and each in-order delivery passes a memory read state, then an
// output state. Frames are taken one at a time, and non-data frames are
// dropped in their accept cycle. Stored frames beyond eight deliveries wait
// for a later data frame.
// Reset clears the expected number and all arrival marks; no clearing pass.
// A stalled result_ready holds the output register and the sequencer waits;
// a new frame may be accepted while the final result of the last one waits.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_crc_top #(
	parameter int MAX_SEQ_NUM   = 7,
	parameter int WINDOW_SIZE   = 4,
	parameter int PAYLOAD_BYTES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_ready,
	input  srrc_pkg::frame_t  frame,
	output logic              result_valid,
	input  logic              result_ready,
	output srrc_pkg::result_t result
);

	localparam int SEQ_SPACE = MAX_SEQ_NUM + 1;
	localparam int EW        = $clog2(SEQ_SPACE);
	localparam int WIN       = (WINDOW_SIZE < SEQ_SPACE) ? WINDOW_SIZE : SEQ_SPACE;

	localparam logic [63:0] LO_MASK = (PAYLOAD_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (PAYLOAD_BYTES * 8)) - 64'd1);
	localparam logic [63:0] HI_MASK = (PAYLOAD_BYTES >= 16) ? {64{1'b1}} :
		(PAYLOAD_BYTES > 8) ? ((64'd1 << ((PAYLOAD_BYTES - 8) * 8)) - 64'd1) : 64'd0;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CRC   = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_DV    = 3'd4;

	logic [2:0]             state_q;
	srrc_pkg::frame_t       fr_q;
	logic [EW-1:0]          exp_q;
	logic [SEQ_SPACE-1:0]   mark_q;
	logic [2:0]             cnt_q;
	srrc_pkg::result_t      res_q;
	logic                   res_valid_q;

	srrc_pkg::frame_t       fr_in;
	logic                   accept;
	logic                   crc_start;
	logic                   crc_done;
	logic [31:0]            crc_val;
	logic                   out_free;
	logic                   res_load;
	logic                   crc_ok;
	logic [EW-1:0]          seq_idx;
	logic                   seq_ok;
	logic [EW:0]            diff;
	logic [EW:0]            off;
	logic                   fresh;
	logic                   deliver;
	logic [EW-1:0]          exp_next;
	logic                   more;
	logic                   mem_wr;
	logic                   mem_rd;
	logic [127:0]           mem_rdata;

	assign frame_ready = (state_q == ST_IDLE);
	assign accept      = frame_valid && frame_ready;
	assign crc_start   = accept && (frame.pkt_kind == srrc_pkg::KIND_DATA);
	assign out_free    = !res_valid_q || result_ready;
	assign res_load    = ((state_q == ST_CHECK) || (state_q == ST_DV)) && out_free;

	srrc_crc #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_crc (
		.clk   (clk),
		.arst_n(arst_n),
		.start (crc_start),
		.data  ({fr_q.payload_hi, fr_q.payload_lo}),
		.done  (crc_done),
		.crc   (crc_val)
	);

	// window test
	assign crc_ok   = (crc_val == fr_q.frame_crc);
	assign seq_idx  = EW'(fr_q.frame_seq);
	assign seq_ok   = int'(fr_q.frame_seq) < SEQ_SPACE;
	assign diff     = {1'b0, seq_idx} - {1'b0, exp_q};
	assign off      = diff[EW] ? (diff + (EW+1)'(SEQ_SPACE)) : diff;
	assign fresh    = seq_ok && (off < (EW+1)'(WIN)) && !mark_q[seq_idx];
	assign deliver  = fresh && (mark_q[exp_q] || (seq_idx == exp_q));
	assign exp_next = (exp_q == EW'(MAX_SEQ_NUM)) ? '0 : (exp_q + EW'(1));
	assign more     = (cnt_q != 3'(srrc_pkg::MAX_DELIV - 1)) && mark_q[exp_next];

	assign mem_wr = (state_q == ST_CHECK) && out_free && crc_ok && fresh;
	assign mem_rd = (state_q == ST_RD);

	srrc_mem #(
		.DEPTH(SEQ_SPACE),
		.AW   (EW)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr),
		.wr_addr(seq_idx),
		.wr_data({fr_q.payload_hi, fr_q.payload_lo}),
		.rd_en  (mem_rd),
		.rd_addr(exp_q),
		.rd_data(mem_rdata)
	);

	always_comb begin
		fr_in            = frame;
		fr_in.payload_lo = frame.payload_lo & LO_MASK;
		fr_in.payload_hi = frame.payload_hi & HI_MASK;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fr_q <= fr_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_q       <= '0;
			mark_q      <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (crc_start) begin
						state_q <= ST_CRC;
					end
				end
				ST_CRC: begin
					if (crc_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (out_free) begin
						cnt_q <= '0;
						if (crc_ok && fresh) begin
							mark_q[seq_idx] <= 1'b1;
						end
						state_q <= (crc_ok && deliver) ? ST_RD : ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_DV;
				end
				ST_DV: begin
					if (out_free) begin
						mark_q[exp_q] <= 1'b0;
						exp_q         <= exp_next;
						cnt_q         <= cnt_q + 3'd1;
						state_q       <= more ? ST_RD : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((state_q == ST_CHECK) && out_free) begin
			res_q.out_type    <= crc_ok ? srrc_pkg::OUT_ACK : srrc_pkg::OUT_NAK;
			res_q.out_seq     <= fr_q.frame_seq;
			res_q.data_lo     <= '0;
			res_q.data_hi     <= '0;
			res_q.last_result <= !(crc_ok && deliver);
		end else if ((state_q == ST_DV) && out_free) begin
			res_q.out_type    <= srrc_pkg::OUT_DELIVER;
			res_q.out_seq     <= 3'(exp_q);
			res_q.data_lo     <= mem_rdata[63:0];
			res_q.data_hi     <= mem_rdata[127:64];
			res_q.last_result <= !more;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule
